FILE: hdl/fapm_pkg.sv
// ----------------------------------------------------------------------------
// fapm_pkg: shared types and constants for the forest path-query block
// Request and response payload structs, operation codes, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package fapm_pkg;

  // default sizes
  localparam int NODES_DEF       = 1024;
  localparam int LEVELS_DEF      = 10;
  localparam int WEIGHT_BITS_DEF = 16;

  // operation codes
  typedef enum logic [1:0] {
    OP_LINK  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // request payload
  typedef struct packed {
    op_t         operation;
    logic [9:0]  node;
    logic [9:0]  other_node;
    logic [15:0] value;
  } req_t;

  // response payload
  typedef struct packed {
    logic [9:0]  common_ancestor;
    logic [15:0] path_max;
    logic        same_tree;
    logic        answer_yes;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hdl/fapm_ram.sv
// ----------------------------------------------------------------------------
// fapm_ram: synchronous RAM, one write port and two read ports
// Read data is registered, old data on collision.
// ----------------------------------------------------------------------------
`default_nettype none

module fapm_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr_a,
  output logic      [W-1:0]  rdata_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [W-1:0]  rdata_b
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

FILE: hdl/forest_ancestor_path_max_query.sv
// ----------------------------------------------------------------------------
// forest_ancestor_path_max_query: binary-lifting LCA and path maximum
// Forest of weighted parent links; jump tables built by pointer doubling.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req (valid/stall); query responses leave on rsp
//   (valid/stall). Link, build and unused operations give no response.
//   One request is in work at a time; req_stall is low only when idle.
//   Link writes its level-0 entry while idle. A query runs the root walk
//   (S_Q_ROOT), depth compare (S_Q_DEP), depth lift (S_Q_LIFT),
//   common-ancestor descent (S_Q_CMP) and last hop (S_Q_LAST) to S_DONE,
//   its dependent table reads one level per cycle on the table RAM.
//   Out-of-range nodes or equal nodes go straight from idle to S_DONE.
//   Build: S_B_RD1, S_B_RD2 and S_B_WR per node per level for levels
//   1..LEVELS-1, then the depth pass: S_D_START and S_D_ROOT per node,
//   plus S_D_UP and S_D_CHK per level for each non-root node.
//   Reset: the table RAM (NODES*2^ceil(log2(LEVELS)) entries) is swept
//   to its reset contents, node depths to zero; requests stall in the sweep.
//   A finished response waits in the output register while rsp_stall is
//   high; the next request is taken meanwhile, and a further response
//   waits in the controller until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module forest_ancestor_path_max_query #(
  parameter int NODES       = fapm_pkg::NODES_DEF,
  parameter int LEVELS      = fapm_pkg::LEVELS_DEF,
  parameter int WEIGHT_BITS = fapm_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire fapm_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output fapm_pkg::rsp_t       rsp
);

  localparam int NW = $clog2(NODES);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW = NW + LW;
  localparam int TD = NODES * (2 ** LW);
  localparam int WB = WEIGHT_BITS;
  localparam int EW = NW + WB;
  localparam int DW = LEVELS;
  localparam logic [LW-1:0] LAST_LVL  = LW'(LEVELS - 1);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TD - 1);

  typedef enum logic [14:0] {
    S_CLEAR   = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_B_RD1   = 15'b000000000000100,
    S_B_RD2   = 15'b000000000001000,
    S_B_WR    = 15'b000000000010000,
    S_D_START = 15'b000000000100000,
    S_D_ROOT  = 15'b000000001000000,
    S_D_UP    = 15'b000000010000000,
    S_D_CHK   = 15'b000000100000000,
    S_Q_ROOT  = 15'b000001000000000,
    S_Q_DEP   = 15'b000010000000000,
    S_Q_LIFT  = 15'b000100000000000,
    S_Q_CMP   = 15'b001000000000000,
    S_Q_LAST  = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_t;

  function automatic logic [AW-1:0] tadr(input logic [NW-1:0] n, input logic [LW-1:0] l);
    return {n, l};
  endfunction

  function automatic logic [WB-1:0] wmax(input logic [WB-1:0] a, input logic [WB-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // registers
  state_t         state, state_next;
  logic [AW-1:0]  clr, clr_next;
  logic [LW-1:0]  lev, lev_next;
  logic [LW-1:0]  idx, idx_next;
  logic [NW-1:0]  vtx, vtx_next;
  logic [NW-1:0]  cur_a, cur_a_next;
  logic [NW-1:0]  cur_b, cur_b_next;
  logic [NW-1:0]  first, first_next;
  logic [WB-1:0]  thr, thr_next;
  logic [WB-1:0]  mx, mx_next;
  logic [WB-1:0]  wtmp, wtmp_next;
  logic [DW-1:0]  dsum, dsum_next;
  logic [DW-1:0]  diff, diff_next;
  fapm_pkg::rsp_t res, res_next;

  // memory ports
  logic           tbl_we;
  logic [AW-1:0]  tbl_waddr, tbl_ra, tbl_rb;
  logic [EW-1:0]  tbl_wdata, tbl_qa, tbl_qb;
  logic           dep_we;
  logic [NW-1:0]  dep_waddr, dep_ra, dep_rb;
  logic [DW-1:0]  dep_wdata, dep_qa, dep_qb;

  fapm_ram #(.W(EW), .D(TD), .AW(AW)) u_tbl (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr_a(tbl_ra), .rdata_a(tbl_qa), .raddr_b(tbl_rb), .rdata_b(tbl_qb)
  );

  fapm_ram #(.W(DW), .D(NODES), .AW(NW)) u_dep (
    .clk, .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
    .raddr_a(dep_ra), .rdata_a(dep_qa), .raddr_b(dep_rb), .rdata_b(dep_qb)
  );

  // table read fields
  logic [NW-1:0] ra_anc, rb_anc;
  logic [WB-1:0] ra_w, rb_w;
  assign ra_anc = tbl_qa[EW-1:WB];
  assign ra_w   = tbl_qa[WB-1:0];
  assign rb_anc = tbl_qb[EW-1:WB];
  assign rb_w   = tbl_qb[WB-1:0];

  // request decode
  logic          accept, na_ok, nb_ok, rsp_free;
  logic [NW-1:0] na, nb;
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign na_ok     = (32'(req.node) < NODES);
  assign nb_ok     = (32'(req.other_node) < NODES);
  assign na        = NW'(req.node);
  assign nb        = NW'(req.other_node);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // scratch for the step logic
  logic          swap, step;
  logic [NW-1:0] a_n, b_n;
  logic [WB-1:0] mx_n;
  logic [DW-1:0] d_n;
  logic [DW:0]   d1;

  // controller
  always_comb begin
    state_next = state;
    clr_next   = clr;
    lev_next   = lev;
    idx_next   = idx;
    vtx_next   = vtx;
    cur_a_next = cur_a;
    cur_b_next = cur_b;
    first_next = first;
    thr_next   = thr;
    mx_next    = mx;
    wtmp_next  = wtmp;
    dsum_next  = dsum;
    diff_next  = diff;
    res_next   = res;
    tbl_we     = 1'b0;
    tbl_waddr  = tadr(vtx, lev);
    tbl_wdata  = '0;
    tbl_ra     = '0;
    tbl_rb     = '0;
    dep_we     = 1'b0;
    dep_waddr  = vtx;
    dep_wdata  = '0;
    dep_ra     = cur_a;
    dep_rb     = cur_b;
    swap       = 1'b0;
    step       = 1'b0;
    a_n        = cur_a;
    b_n        = cur_b;
    mx_n       = mx;
    d_n        = dsum;
    d1         = '0;

    unique case (state)
      // reset sweep: every entry points to its own node, weight zero
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr;
        tbl_wdata = {clr[AW-1:LW], {WB{1'b0}}};
        dep_we    = (clr[LW-1:0] == '0);
        dep_waddr = clr[AW-1:LW];
        if (clr == LAST_ADDR) begin
          state_next = S_IDLE;
        end else begin
          clr_next = clr + AW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            fapm_pkg::OP_LINK: begin
              tbl_we    = na_ok && nb_ok;
              tbl_waddr = tadr(na, '0);
              tbl_wdata = {nb, (na == nb) ? {WB{1'b0}} : WB'(req.value)};
            end
            fapm_pkg::OP_BUILD: begin
              vtx_next = '0;
              lev_next = LW'(1);
              state_next = (LEVELS > 1) ? S_B_RD1 : S_D_START;
            end
            fapm_pkg::OP_QUERY: begin
              first_next = na;
              cur_a_next = na;
              cur_b_next = nb;
              thr_next   = WB'(req.value);
              mx_next    = '0;
              idx_next   = '0;
              if (!(na_ok && nb_ok)) begin
                res_next   = '0;
                state_next = S_DONE;
              end else if (na == nb) begin
                res_next.common_ancestor = 10'(na);
                res_next.path_max        = '0;
                res_next.same_tree       = 1'b1;
                res_next.answer_yes      = 1'b1;
                state_next = S_DONE;
              end else begin
                tbl_ra     = tadr(na, '0);
                tbl_rb     = tadr(nb, '0);
                state_next = S_Q_ROOT;
              end
            end
            default: ;
          endcase
        end
      end

      // build: one level from the one below
      S_B_RD1: begin
        tbl_ra     = tadr(vtx, lev - LW'(1));
        state_next = S_B_RD2;
      end
      S_B_RD2: begin
        wtmp_next  = ra_w;
        tbl_ra     = tadr(ra_anc, lev - LW'(1));
        state_next = S_B_WR;
      end
      S_B_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = tadr(vtx, lev);
        tbl_wdata = {ra_anc, wmax(wtmp, ra_w)};
        if (vtx == LAST_NODE) begin
          vtx_next = '0;
          if (lev == LAST_LVL) begin
            state_next = S_D_START;
          end else begin
            lev_next   = lev + LW'(1);
            state_next = S_B_RD1;
          end
        end else begin
          vtx_next   = vtx + NW'(1);
          state_next = S_B_RD1;
        end
      end

      // depth pass: climb while the next hop is not a root
      S_D_START: begin
        tbl_ra     = tadr(vtx, '0);
        state_next = S_D_ROOT;
      end
      S_D_ROOT: begin
        if (ra_anc == vtx) begin
          dep_we    = 1'b1;
          dep_wdata = '0;
          vtx_next   = vtx + NW'(1);
          state_next = (vtx == LAST_NODE) ? S_IDLE : S_D_START;
        end else begin
          cur_a_next = vtx;
          dsum_next  = '0;
          idx_next   = LAST_LVL;
          tbl_ra     = tadr(vtx, LAST_LVL);
          state_next = S_D_UP;
        end
      end
      S_D_UP: begin
        cur_b_next = ra_anc;
        tbl_ra     = tadr(ra_anc, '0);
        state_next = S_D_CHK;
      end
      S_D_CHK: begin
        step = (ra_anc != cur_b);
        a_n  = step ? cur_b : cur_a;
        d_n  = step ? (dsum | (DW'(1) << idx)) : dsum;
        cur_a_next = a_n;
        dsum_next  = d_n;
        if (idx == '0) begin
          d1        = {1'b0, d_n} + (DW + 1)'(1);
          dep_we    = 1'b1;
          dep_wdata = d1[DW] ? {DW{1'b1}} : d1[DW-1:0];
          vtx_next   = vtx + NW'(1);
          state_next = (vtx == LAST_NODE) ? S_IDLE : S_D_START;
        end else begin
          idx_next   = idx - LW'(1);
          tbl_ra     = tadr(a_n, idx - LW'(1));
          state_next = S_D_UP;
        end
      end

      // query: walk both nodes to their roots
      S_Q_ROOT: begin
        if (idx == LAST_LVL) begin
          if (ra_anc != rb_anc) begin
            res_next   = '0;
            state_next = S_DONE;
          end else begin
            dep_ra     = cur_a;
            dep_rb     = cur_b;
            state_next = S_Q_DEP;
          end
        end else begin
          idx_next = idx + LW'(1);
          tbl_ra   = tadr(ra_anc, idx + LW'(1));
          tbl_rb   = tadr(rb_anc, idx + LW'(1));
        end
      end
      // order by depth, the deeper one becomes cur_b
      S_Q_DEP: begin
        swap       = (dep_qb < dep_qa);
        a_n        = swap ? cur_b : cur_a;
        b_n        = swap ? cur_a : cur_b;
        cur_a_next = a_n;
        cur_b_next = b_n;
        diff_next  = swap ? (dep_qa - dep_qb) : (dep_qb - dep_qa);
        idx_next   = LAST_LVL;
        tbl_rb     = tadr(b_n, LAST_LVL);
        state_next = S_Q_LIFT;
      end
      // lift the deeper node by the depth difference
      S_Q_LIFT: begin
        step = diff[idx];
        b_n  = step ? rb_anc : cur_b;
        mx_n = step ? wmax(mx, rb_w) : mx;
        cur_b_next = b_n;
        mx_next    = mx_n;
        if (idx == '0) begin
          if (cur_a == b_n) begin
            res_next.common_ancestor = 10'(cur_a);
            res_next.path_max        = 16'(mx_n);
            res_next.same_tree       = 1'b1;
            res_next.answer_yes      = (cur_a == first) && (mx_n <= thr);
            state_next = S_DONE;
          end else begin
            idx_next   = LAST_LVL;
            tbl_ra     = tadr(cur_a, LAST_LVL);
            tbl_rb     = tadr(b_n, LAST_LVL);
            state_next = S_Q_CMP;
          end
        end else begin
          idx_next = idx - LW'(1);
          tbl_rb   = tadr(b_n, idx - LW'(1));
        end
      end
      // descend together while the jumps differ
      S_Q_CMP: begin
        step = (ra_anc != rb_anc);
        a_n  = step ? ra_anc : cur_a;
        b_n  = step ? rb_anc : cur_b;
        mx_n = step ? wmax(mx, wmax(ra_w, rb_w)) : mx;
        cur_a_next = a_n;
        cur_b_next = b_n;
        mx_next    = mx_n;
        if (idx == '0) begin
          tbl_ra     = tadr(a_n, '0);
          tbl_rb     = tadr(b_n, '0);
          state_next = S_Q_LAST;
        end else begin
          idx_next = idx - LW'(1);
          tbl_ra   = tadr(a_n, idx - LW'(1));
          tbl_rb   = tadr(b_n, idx - LW'(1));
        end
      end
      // final hop of both sides to the common parent
      S_Q_LAST: begin
        mx_n = wmax(mx, wmax(ra_w, rb_w));
        res_next.common_ancestor = 10'(ra_anc);
        res_next.path_max        = 16'(mx_n);
        res_next.same_tree       = 1'b1;
        res_next.answer_yes      = (ra_anc == first) && (mx_n <= thr);
        state_next = S_DONE;
      end

      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    lev   <= lev_next;
    idx   <= idx_next;
    vtx   <= vtx_next;
    cur_a <= cur_a_next;
    cur_b <= cur_b_next;
    first <= first_next;
    thr   <= thr_next;
    mx    <= mx_next;
    wtmp  <= wtmp_next;
    dsum  <= dsum_next;
    diff  <= diff_next;
    res   <= res_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fapm_checker.sv
// ----------------------------------------------------------------------------
// fapm_checker: port-level checks for the forest path-query block
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fapm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire fapm_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire fapm_pkg::rsp_t rsp
);

  // reset starts the sweep: no request taken, no response shown
  a_reset_quiet: assert property (@(posedge clk) rst |=> req_stall && !rsp_valid)
    else $error("request taken or response shown right after reset");

  // a stalled response stays valid
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("stalled response dropped");

  // a stalled response holds its payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("stalled response changed");

  // different trees or bad nodes give an all-zero response
  a_no_tree: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.same_tree |->
      !rsp.answer_yes && rsp.common_ancestor == '0 && rsp.path_max == '0)
    else $error("response outside one tree is not all zero");

  // a yes answer only comes from within one tree
  a_yes_tree: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.answer_yes |-> rsp.same_tree)
    else $error("yes answer without a common tree");

endmodule

bind forest_ancestor_path_max_query fapm_checker u_fapm_checker (.*);

`default_nettype wire
